[hdl/dual_circular_stack_unit_core_assert.svh]
// ----------------------------------------------------------------------------
// dual circular stack unit assertion macros
// shared property forms for the stack unit checks
// ----------------------------------------------------------------------------
`ifndef DUAL_CIRCULAR_STACK_UNIT_CORE_ASSERT_SVH
`define DUAL_CIRCULAR_STACK_UNIT_CORE_ASSERT_SVH

// same-cycle implication, reset masks the check
`define DCSU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("dcsu check failed");

// next-cycle implication, reset masks the check
`define DCSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("dcsu check failed");

`endif

[hdl/dcsu_pkg.sv]
// ----------------------------------------------------------------------------
// dcsu_pkg
// shared widths, operation codes and control types of the stack unit
// ----------------------------------------------------------------------------
package dcsu_pkg;

	localparam int DATA_W           = 64;
	localparam int OP_W             = 4;
	localparam int DEF_PARAM_DEPTH  = 8;
	localparam int DEF_RETURN_DEPTH = 8;

	localparam logic [OP_W-1:0] OP_LITERAL    = 4'd0;
	localparam logic [OP_W-1:0] OP_DUP        = 4'd1;
	localparam logic [OP_W-1:0] OP_OVER       = 4'd2;
	localparam logic [OP_W-1:0] OP_UNDER      = 4'd3;
	localparam logic [OP_W-1:0] OP_SWAP       = 4'd4;
	localparam logic [OP_W-1:0] OP_DROP       = 4'd5;
	localparam logic [OP_W-1:0] OP_NIP        = 4'd6;
	localparam logic [OP_W-1:0] OP_PUSH_PARAM = 4'd7;
	localparam logic [OP_W-1:0] OP_POP_PARAM  = 4'd8;
	localparam logic [OP_W-1:0] OP_PUSH_RET   = 4'd9;
	localparam logic [OP_W-1:0] OP_POP_RET    = 4'd10;

	// per-cycle command to a row of stack cells
	typedef struct packed {
		logic push;
		logic pop;
	} stk_ctl_t;

endpackage

[hdl/dcsu_cell.sv]
// ----------------------------------------------------------------------------
// dcsu_cell
// one entry of a circular stack row: shifts down on push, rotates up on pop
// ----------------------------------------------------------------------------
module dcsu_cell import dcsu_pkg::*; #(
	parameter int W = DATA_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  stk_ctl_t     ctl,
	input  logic [W-1:0] shift_in,   // neighbour nearer the top
	input  logic [W-1:0] rot_in,     // neighbour further down
	output logic [W-1:0] data_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (ctl.push) begin
			data_q <= shift_in;
		end else if (ctl.pop) begin
			data_q <= rot_in;
		end
	end

endmodule

[hdl/dcsu_ring.sv]
// ----------------------------------------------------------------------------
// dcsu_ring
// circular stack as a row of cells, cell 0 is the entry under the pointer
// ----------------------------------------------------------------------------
module dcsu_ring import dcsu_pkg::*; #(
	parameter int DEPTH = DEF_PARAM_DEPTH,
	parameter int W     = DATA_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  stk_ctl_t     ctl,
	input  logic [W-1:0] push_data,
	output logic [W-1:0] top_data
);

	logic [W-1:0] cell_q [DEPTH];

	genvar k;
	generate
		for (k = 0; k < DEPTH; k++) begin : g_cell
			logic [W-1:0] shift_src;
			logic [W-1:0] rot_src;

			// push drops the oldest entry off the end, pop wraps cell 0 round
			if (k == 0) begin : g_head
				assign shift_src = push_data;
			end else begin : g_body
				assign shift_src = cell_q[k-1];
			end
			if (k == DEPTH-1) begin : g_tail
				assign rot_src = cell_q[0];
			end else begin : g_mid
				assign rot_src = cell_q[k+1];
			end

			dcsu_cell #(
				.W(W)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.shift_in(shift_src),
				.rot_in  (rot_src),
				.data_q  (cell_q[k])
			);
		end
	endgenerate

	assign top_data = cell_q[0];

endmodule

[hdl/dual_circular_stack_unit_core.sv]
// ----------------------------------------------------------------------------
// dual_circular_stack_unit_core
// top/second registers with circular parameter and return stacks
// ----------------------------------------------------------------------------
// result: shows on m_tvalid in the cycle after its request is taken
// throughput: one request per cycle unless a result waits with m_tready low, all stack cells move in the same cycle
// a new request is taken while the previous result waits, if m_tready is high
// reset: top, second and every stack cell cleared to zero at once, no sweep
// ----------------------------------------------------------------------------
module dual_circular_stack_unit_core import dcsu_pkg::*; #(
	parameter int PARAM_DEPTH  = DEF_PARAM_DEPTH,
	parameter int RETURN_DEPTH = DEF_RETURN_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	// request side
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // [63:0] value
	input  logic [OP_W-1:0]   s_tuser,   // [3:0] operation
	// result side
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [3*DATA_W-1:0] m_tdata  // [63:0] top_value, [127:64] second_value,
	                                     // [191:128] removed_value
);

`include "dual_circular_stack_unit_core_assert.svh"

	// architectural registers
	logic [DATA_W-1:0] top_q;
	logic [DATA_W-1:0] second_q;

	// result register
	logic                out_valid_q;
	logic [3*DATA_W-1:0] out_data_q;

	// next-state values
	logic [DATA_W-1:0] top_d;
	logic [DATA_W-1:0] second_d;
	logic [DATA_W-1:0] removed_d;

	// stack rows
	stk_ctl_t          p_cmd;
	stk_ctl_t          r_cmd;
	stk_ctl_t          p_ctl;
	stk_ctl_t          r_ctl;
	logic [DATA_W-1:0] p_wdata;
	logic [DATA_W-1:0] p_top;
	logic [DATA_W-1:0] r_top;

	logic              in_acc;
	logic [OP_W-1:0]   op;
	logic [DATA_W-1:0] value;

	assign op    = s_tuser;
	assign value = s_tdata;

	// the result register frees up in the same cycle it is taken
	assign s_tready = !out_valid_q || m_tready;
	assign in_acc   = s_tvalid && s_tready;

	// operation decode, unused codes change nothing and remove nothing
	always_comb begin
		top_d     = top_q;
		second_d  = second_q;
		removed_d = '0;
		p_cmd     = '0;
		r_cmd     = '0;
		p_wdata   = second_q;
		case (op)
			OP_LITERAL: begin
				p_cmd.push = 1'b1;
				second_d   = top_q;
				top_d      = value;
			end
			OP_DUP: begin
				p_cmd.push = 1'b1;
				second_d   = top_q;
			end
			OP_OVER: begin
				p_cmd.push = 1'b1;
				second_d   = top_q;
				top_d      = second_q;
			end
			OP_UNDER: begin
				p_cmd.push = 1'b1;
			end
			OP_SWAP: begin
				second_d = top_q;
				top_d    = second_q;
			end
			OP_DROP: begin
				p_cmd.pop = 1'b1;
				removed_d = top_q;
				top_d     = second_q;
				second_d  = p_top;
			end
			OP_NIP: begin
				p_cmd.pop = 1'b1;
				removed_d = second_q;
				second_d  = p_top;
			end
			OP_PUSH_PARAM: begin
				p_cmd.push = 1'b1;
				p_wdata    = value;
			end
			OP_POP_PARAM: begin
				p_cmd.pop = 1'b1;
				removed_d = p_top;
			end
			OP_PUSH_RET: begin
				r_cmd.push = 1'b1;
			end
			OP_POP_RET: begin
				r_cmd.pop = 1'b1;
				removed_d = r_top;
			end
			default: begin
			end
		endcase
	end

	// stacks only move on a taken request
	assign p_ctl.push = p_cmd.push && in_acc;
	assign p_ctl.pop  = p_cmd.pop && in_acc;
	assign r_ctl.push = r_cmd.push && in_acc;
	assign r_ctl.pop  = r_cmd.pop && in_acc;

	// parameter stack row
	dcsu_ring #(
		.DEPTH(PARAM_DEPTH),
		.W    (DATA_W)
	) u_param_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (p_ctl),
		.push_data(p_wdata),
		.top_data (p_top)
	);

	// return stack row, pushes always take the request value
	dcsu_ring #(
		.DEPTH(RETURN_DEPTH),
		.W    (DATA_W)
	) u_return_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (r_ctl),
		.push_data(value),
		.top_data (r_top)
	);

	// top and second registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q    <= '0;
			second_q <= '0;
		end else if (in_acc) begin
			top_q    <= top_d;
			second_q <= second_d;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, loaded only with a taken request
	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_data_q <= {removed_d, second_d, top_d};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// a taken request always leaves a result behind
	`DCSU_ASSERT_NEXT(a_result_follows, clk, arst_n, in_acc, out_valid_q)
	// neither stack row pushes and pops in the same cycle
	`DCSU_ASSERT_NOW(a_no_push_pop_p, clk, arst_n, 1'b1, !(p_ctl.push && p_ctl.pop))
	`DCSU_ASSERT_NOW(a_no_push_pop_r, clk, arst_n, 1'b1, !(r_ctl.push && r_ctl.pop))
	// drop promotes second into top
	`DCSU_ASSERT_NEXT(a_drop_top, clk, arst_n, in_acc && (op == OP_DROP), top_q == $past(second_q))
	// a raw parameter push lands in the head cell
	`DCSU_ASSERT_NEXT(a_push_head, clk, arst_n, in_acc && (op == OP_PUSH_PARAM), p_top == $past(value))
	// the result mirrors the registers it reports
	`DCSU_ASSERT_NEXT(a_result_regs, clk, arst_n, in_acc, (out_data_q[2*DATA_W-1:0] == {second_q, top_q}))

endmodule
